[rtl/crrm_pkg.sv]
package crrm_pkg;

  localparam int NUM_STAGES = 7;
  localparam int ENTRIES    = 64;
  localparam int VAL_W      = 32;
  localparam int DEPTH      = NUM_STAGES * ENTRIES;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ST_W       = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // fixed field widths of the stream payload
  localparam int MODE_W     = 2;
  localparam int STAGE_FW   = 3;
  localparam int SLOT_FW    = 6;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 64;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0] dest;
    logic [VAL_W-1:0] src;
    logic [VAL_W-1:0] len;
  } crrm_entry_t;

  typedef struct packed {
    logic              ent_we;
    logic              vld_we;
    logic              vld_bit;
    logic [ADDR_W-1:0] addr;
  } crrm_wr_t;

endpackage

[rtl/chained_range_remap_min.sv]
// Chained range remapper with running minimum; one item at a time, in_tready low meanwhile.
// Load: the entry is written on the transfer. Clear: valid-bit sweep, one entry per cycle.
// Query: the single read port compares one entry per cycle over the 7 x 64 entries, stage by
// stage; a stage hit skips the rest of that stage and goes to the add state, which starts
// the next stage or ends the scan; an output stall delays the result and in_tready.
// Reset (rst_n low, synchronous): control cleared, minimum all ones, then the valid-bit sweep.
module chained_range_remap_min import crrm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // stage[2:0], slot[8:3], dest_start[40:9], src_start[72:41],
  // span_length[104:73], query_value[136:105], zero fill above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode[1:0]
  input  logic [MODE_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // final_value[31:0], running_min[63:32]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;  // valid-bit sweep
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;  // stream reads, compare one entry per cycle
  localparam logic [2:0] S_ADD  = 3'd3;  // dest + offset after a hit
  localparam logic [2:0] S_DONE = 3'd4;  // update minimum, hand off result

  // input field unpack
  logic [STAGE_FW-1:0] in_stage;
  logic [SLOT_FW-1:0]  in_slot;
  crrm_entry_t         in_ent;
  logic [VAL_W-1:0]    in_query;

  assign in_stage   = in_tdata[2:0];
  assign in_slot    = in_tdata[8:3];
  assign in_ent.dest = in_tdata[40:9];
  assign in_ent.src  = in_tdata[72:41];
  assign in_ent.len  = in_tdata[104:73];
  assign in_query   = in_tdata[136:105];

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [VAL_W-1:0]  v_r, v_nxt;
  logic [VAL_W-1:0]  min_r, min_nxt;

  // read issue side
  logic [ADDR_W-1:0] iss_addr_r, iss_addr_nxt;
  logic [SLOT_W-1:0] iss_slot_r, iss_slot_nxt;
  logic [ST_W-1:0]   iss_stage_r, iss_stage_nxt;
  logic              iss_done_r, iss_done_nxt;

  // compare side: tags for the entry whose read data is now out of the memory
  logic              pv_r, pv_nxt;
  logic              p_last_r, p_last_nxt;
  logic [ST_W-1:0]   p_stage_r, p_stage_nxt;

  // hit capture
  logic [VAL_W-1:0]  diff_r, diff_nxt;
  logic [VAL_W-1:0]  dest_r, dest_nxt;

  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  crrm_wr_t    wr;
  crrm_entry_t rd_ent;
  logic        rd_vld;

  logic              in_xfer;
  logic              load_ok;
  logic [ADDR_W-1:0] load_addr;
  logic              issue;
  logic [VAL_W-1:0]  diff;
  logic              hit;
  logic [VAL_W-1:0]  new_min;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  assign load_ok   = (int'(in_stage) < NUM_STAGES) && (int'(in_slot) < ENTRIES);
  assign load_addr = ADDR_W'(ADDR_W'(in_stage) * ADDR_W'(ENTRIES) + ADDR_W'(in_slot));

  assign issue = (state_r == S_SCAN) && !iss_done_r;

  // shared compare unit: v >= src and v - src < len, no wrap on the range end
  assign diff = v_r - rd_ent.src;
  assign hit  = pv_r && rd_vld && (v_r >= rd_ent.src) && (diff < rd_ent.len);

  assign new_min = (v_r < min_r) ? v_r : min_r;

  crrm_mem u_mem (
    .clk    (clk),
    .wr     (wr),
    .wdata  (in_ent),
    .raddr  (iss_addr_r),
    .rd_ent (rd_ent),
    .rd_vld (rd_vld)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    v_nxt          = v_r;
    min_nxt        = min_r;
    iss_addr_nxt   = iss_addr_r;
    iss_slot_nxt   = iss_slot_r;
    iss_stage_nxt  = iss_stage_r;
    iss_done_nxt   = iss_done_r;
    pv_nxt         = 1'b0;
    p_last_nxt     = p_last_r;
    p_stage_nxt    = p_stage_r;
    diff_nxt       = diff_r;
    dest_nxt       = dest_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    wr             = '0;

    unique case (state_r)
      S_CLR: begin
        wr.vld_we = 1'b1;
        wr.addr   = clr_addr_r;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          case (in_tuser)
            MODE_LOAD: begin
              wr.ent_we  = load_ok;
              wr.vld_we  = load_ok;
              wr.vld_bit = 1'b1;
              wr.addr    = load_addr;
            end
            MODE_QUERY: begin
              v_nxt         = in_query;
              iss_addr_nxt  = '0;
              iss_slot_nxt  = '0;
              iss_stage_nxt = '0;
              iss_done_nxt  = 1'b0;
              state_nxt     = S_SCAN;
            end
            MODE_CLEAR: begin
              min_nxt      = '1;
              clr_addr_nxt = '0;
              state_nxt    = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (issue) begin
          pv_nxt       = 1'b1;
          p_last_nxt   = (iss_slot_r == SLOT_W'(ENTRIES - 1));
          p_stage_nxt  = iss_stage_r;
          iss_done_nxt = (iss_addr_r == ADDR_W'(DEPTH - 1));
          iss_addr_nxt = iss_addr_r + 1'b1;
          if (iss_slot_r == SLOT_W'(ENTRIES - 1)) begin
            iss_slot_nxt  = '0;
            iss_stage_nxt = iss_stage_r + 1'b1;
          end else begin
            iss_slot_nxt = iss_slot_r + 1'b1;
          end
        end
        if (hit) begin
          // first hit in slot order wins; drop the read in flight
          pv_nxt      = 1'b0;
          p_stage_nxt = p_stage_r;
          diff_nxt    = diff;
          dest_nxt    = rd_ent.dest;
          state_nxt   = S_ADD;
        end else if (pv_r && p_last_r && (p_stage_r == ST_W'(NUM_STAGES - 1))) begin
          state_nxt = S_DONE;
        end
      end
      S_ADD: begin
        v_nxt = dest_r + diff_r;
        if (p_stage_r == ST_W'(NUM_STAGES - 1)) begin
          state_nxt = S_DONE;
        end else begin
          // restart the read stream at the next stage's first slot
          iss_stage_nxt = p_stage_r + 1'b1;
          iss_addr_nxt  = ADDR_W'(ADDR_W'(iss_stage_nxt) * ADDR_W'(ENTRIES));
          iss_slot_nxt  = '0;
          iss_done_nxt  = 1'b0;
          state_nxt     = S_SCAN;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          min_nxt        = new_min;
          out_tdata_nxt  = {new_min, v_r};
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_addr_r   <= '0;
      min_r        <= '1;
      iss_done_r   <= 1'b0;
      pv_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      min_r        <= min_nxt;
      iss_done_r   <= iss_done_nxt;
      pv_r         <= pv_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r         <= v_nxt;
    iss_addr_r  <= iss_addr_nxt;
    iss_slot_r  <= iss_slot_nxt;
    iss_stage_r <= iss_stage_nxt;
    p_last_r    <= p_last_nxt;
    p_stage_r   <= p_stage_nxt;
    diff_r      <= diff_nxt;
    dest_r      <= dest_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // the reported minimum never exceeds the reported value
  a_min_le_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_tdata_r[63:32] <= out_tdata_r[31:0]))
    else $error("running minimum above final value");

  // a clear transfer starts the sweep at entry zero
  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_tuser == MODE_CLEAR)) |=> ((state_r == S_CLR) && (clr_addr_r == '0)))
    else $error("clear did not start sweep");

  // no compare tag survives into the add or hand-off states
  a_no_stale_tag: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_ADD) || (state_r == S_DONE)) |-> !pv_r)
    else $error("stale read tag");

  // a new result only comes out of the hand-off state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !$past(out_tvalid_r)) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside hand-off");

  // a query transfer starts the scan with the read stream armed
  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_tuser == MODE_QUERY)) |=> ((state_r == S_SCAN) && !iss_done_r))
    else $error("query did not start scan");

endmodule

[rtl/crrm_mem.sv]
module crrm_mem import crrm_pkg::*; (
  input  logic              clk,
  input  crrm_wr_t          wr,
  input  crrm_entry_t       wdata,
  input  logic [ADDR_W-1:0] raddr,
  output crrm_entry_t       rd_ent,
  output logic              rd_vld
);

  crrm_entry_t ent_mem [DEPTH];
  logic        vld_mem [DEPTH];
  crrm_entry_t rd_ent_r;
  logic        rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.ent_we) begin
      ent_mem[wr.addr] <= wdata;
    end
    if (wr.vld_we) begin
      vld_mem[wr.addr] <= wr.vld_bit;
    end
    rd_ent_r <= ent_mem[raddr];
    rd_vld_r <= vld_mem[raddr];
  end

  assign rd_ent = rd_ent_r;
  assign rd_vld = rd_vld_r;

endmodule

[tb/sv/remap_checker.sv]
`timescale 1ns / 100ps

// Watches both streams, predicts each query result from a private copy of the
// remap tables and compares results in order.
module remap_checker import crrm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [MODE_W-1:0]     in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct packed {
    logic [VAL_W-1:0] running_min;
    logic [VAL_W-1:0] final_value;
  } remap_result_t;

  remap_result_t    pending_results[$];
  logic [VAL_W-1:0] dest_mem [DEPTH];
  logic [VAL_W-1:0] src_mem  [DEPTH];
  logic [VAL_W-1:0] len_mem  [DEPTH];
  logic             entry_live [DEPTH];
  logic [VAL_W-1:0] low_water;
  int               err_total;

  // first live slot per stage wins; end of range compared without wrap
  function automatic logic [VAL_W-1:0] chain_remap(input logic [VAL_W-1:0] start);
    logic [VAL_W-1:0] v;
    logic             hit;
    int               s;
    int               e;
    int               idx;
    v = start;
    for (s = 0; s < NUM_STAGES; s++) begin
      hit = 1'b0;
      for (e = 0; e < ENTRIES; e++) begin
        idx = s * ENTRIES + e;
        if (!hit && entry_live[idx] && v >= src_mem[idx] &&
            (v - src_mem[idx]) < len_mem[idx]) begin
          v   = dest_mem[idx] + (v - src_mem[idx]);
          hit = 1'b1;
        end
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin : track
    remap_result_t want;
    remap_result_t got;
    logic [2:0]    stage_f;
    logic [5:0]    slot_f;
    int            idx;
    int            i;
    if (!rst_n) begin
      for (i = 0; i < DEPTH; i++) entry_live[i] = 1'b0;
      low_water = '1;
      pending_results.delete();
      err_total = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        stage_f = in_tdata[2:0];
        slot_f  = in_tdata[8:3];
        case (in_tuser)
          MODE_LOAD: begin
            if (stage_f < NUM_STAGES && slot_f < ENTRIES) begin
              idx = stage_f * ENTRIES + slot_f;
              dest_mem[idx]   = in_tdata[40:9];
              src_mem[idx]    = in_tdata[72:41];
              len_mem[idx]    = in_tdata[104:73];
              entry_live[idx] = 1'b1;
            end
          end
          MODE_QUERY: begin
            want.final_value = chain_remap(in_tdata[136:105]);
            if (want.final_value < low_water) low_water = want.final_value;
            want.running_min = low_water;
            pending_results = {pending_results, want};
          end
          MODE_CLEAR: begin
            for (i = 0; i < DEPTH; i++) entry_live[i] = 1'b0;
            low_water = '1;
          end
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.final_value = out_tdata[31:0];
        got.running_min = out_tdata[63:32];
        if (pending_results.size() == 0) begin
          if (err_total < 10)
            $display("%0t: result with none pending: final %h min %h",
                     $realtime, got.final_value, got.running_min);
          err_total++;
        end else begin
          want = pending_results.pop_front();
          if (got != want) begin
            if (err_total < 10)
              $display("%0t: final exp %h got %h, min exp %h got %h", $realtime,
                       want.final_value, got.final_value,
                       want.running_min, got.running_min);
            err_total++;
          end
        end
      end
    end
    fail_count  <= err_total;
    outstanding <= pending_results.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import crrm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;  // unused code, block ignores it
  localparam int STALL_LIMIT = 12000;  // cycles without any transfer
  localparam int HOLD_CYCLES = 1500;   // one long receiver hold-off
  localparam int RANDOM_ITEMS = 1308;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [MODE_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  int fail_count;
  int outstanding;
  int results_seen;
  int idle_cycles;
  int burst_left;

  chained_range_remap_min u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  remap_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: any transfer on either side restarts the count. Covers the
  // clearing sweep after reset, a full query, and the long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles  <= 0;
      results_seen <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
      if (out_tvalid && out_tready) results_seen <= results_seen + 1;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Value picker: mostly a narrow window so loads and queries overlap and
  // chains actually hit; some full-range, near-top and corner values.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      6, 7:    return $urandom;
      8:       return 32'hFFFF_FFFF - $urandom_range(0, 2000);
      9:       return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 2000);
    endcase
  endfunction

  // span: zero never matches, huge spans run past the top of the value space
  function automatic logic [31:0] pick_span();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return $urandom;
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 100);
      default: return $urandom_range(1, 600);
    endcase
  endfunction

  // Sender: bursts of back-to-back transfers with random gaps in between.
  task automatic push_item(input logic [MODE_W-1:0] mode, input logic [2:0] stage,
                           input logic [5:0] slot, input logic [31:0] dest,
                           input logic [31:0] src, input logic [31:0] span,
                           input logic [31:0] qval);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    // stage, slot, dest_start, src_start, span_length, query_value from bit 0
    in_tdata  <= {7'd0, qval, span, src, dest, slot, stage};
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic load_entry(input logic [2:0] stage, input logic [5:0] slot,
                            input logic [31:0] dest, input logic [31:0] src,
                            input logic [31:0] span);
    push_item(MODE_LOAD, stage, slot, dest, src, span, $urandom);
  endtask

  task automatic query(input logic [31:0] qval);
    push_item(MODE_QUERY, 3'($urandom), 6'($urandom), $urandom, $urandom, $urandom, qval);
  endtask

  // stop offering until every predicted result has been taken
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 44)
      load_entry(3'($urandom_range(0, NUM_STAGES - 1)),
                 6'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 7)
                                                 : $urandom_range(0, 63)),
                 pick_value(), pick_value(), pick_span());
    else if (pick < 46)
      load_entry(STAGE_FW'(NUM_STAGES), 6'($urandom), $urandom, $urandom, $urandom);
    else if (pick < 97)
      query(pick_value());
    else if (pick < 98)
      push_item(MODE_CLEAR, 3'($urandom), 6'($urandom), $urandom, $urandom, $urandom,
                $urandom);
    else
      push_item(MODE_SPARE, 3'($urandom), 6'($urandom), $urandom, $urandom, $urandom,
                $urandom);
  endtask

  // Receiver: stretches of always-ready, coin-flip, mostly-ready and
  // mostly-stalled; one long hold-off once results are flowing, so the
  // block parks a result and stalls its input while the sender keeps offering.
  initial begin : rx_side
    int  style;
    int  run_len;
    bit  held;
    held = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      style   = $urandom_range(0, 3);
      run_len = $urandom_range(10, 300);
      repeat (run_len) begin
        if (!held && results_seen >= 40) begin
          held = 1'b1;
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (style)
            0:       out_tready <= 1'b1;
            1:       out_tready <= 1'($urandom_range(0, 1));
            2:       out_tready <= ($urandom_range(0, 7) != 0);
            default: out_tready <= ($urandom_range(0, 7) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stim
    int i;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= MODE_LOAD;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty tables: pass-through, minimum starts at all ones
    query(32'hFFFF_FFFF);
    query(32'h0000_0000);
    push_item(MODE_CLEAR, 3'd0, 6'd0, '0, '0, '0, '0);
    // overlapping ranges in stage 0: lower slot wins, zero span never matches,
    // destination near the top wraps
    load_entry(3'd0, 6'd5, 32'hFFFF_FFFB, 32'd100, 32'd10);
    load_entry(3'd0, 6'd2, 32'd900, 32'd105, 32'd0);
    load_entry(3'd0, 6'd3, 32'd500, 32'd104, 32'd3);
    // last stage, last slot: range end runs past the top of the value space
    load_entry(3'd6, 6'd63, 32'd7, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    // stage out of range and the unused code: both ignored
    load_entry(STAGE_FW'(NUM_STAGES), 6'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    push_item(MODE_SPARE, 3'h7, 6'h3F, '1, '1, '1, '1);
    query(32'd104);
    query(32'd100);
    query(32'd109);
    query(32'd110);
    query(32'hFFFF_FFFF);
    query(32'd0);
    // chain stage 0 into stage 1
    load_entry(3'd1, 6'd0, 32'h1234_5678, 32'd500, 32'd1);
    query(32'd104);
    // all-ones entry in slot 0 beats slot 63
    load_entry(3'd6, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    query(32'hFFFF_FFFF);
    push_item(MODE_CLEAR, 3'd0, 6'd0, '0, '0, '0, '0);
    query(32'd104);
    wait_drained();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      random_item();
      if (i == RANDOM_ITEMS / 2) wait_drained();
    end

    wait_drained();
    repeat (600) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[chained_range_remap_min.f]
rtl/crrm_pkg.sv
rtl/crrm_mem.sv
rtl/chained_range_remap_min.sv
tb/sv/remap_checker.sv
tb/sv/tb.sv
